// ===== rtl/core/tsp_pkg.sv =====
// Shared types and constants of the two-stream timestamp pairing block.
`default_nettype none

package tsp_pkg;

    // Most result items one input item can cause.
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = 5;
    localparam int IDX_W       = 32;
    localparam int CNT32_W     = 32;
    localparam int THR_W       = 24;
    localparam int MQ_W        = 5;
    localparam int CFG_AW      = 1;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_AW-1:0] REG_MAX_QUEUE = 1'b1;

    // Threshold after reset, and queue limit after reset.
    localparam logic [THR_W-1:0] THR_RESET = 24'd50000;
    localparam logic [MQ_W-1:0]  MQ_RESET  = 5'd10;
    localparam logic [MQ_W-1:0]  MQ_MIN    = 5'd2;

    // Which addresses the queue read ports look at.
    typedef enum logic [1:0] {
        t_RS_SCAN    = 2'd0,
        t_RS_BEST    = 2'd1,
        t_RS_STALE_C = 2'd2,
        t_RS_STALE_D = 2'd3
    } t_rsel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  c_drop;
        logic  c_push;
        logic  d_drop;
        logic  d_push;
        logic  scan_clear;
        logic  scan_step;
        logic  pair;
        logic  status_load;
        t_rsel rsel;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic c_trim;
        logic d_trim;
        logic has_c;
        logic has_d;
        logic c_empty;
        logic d_empty;
        logic scan_last;
        logic best_ok;
        logic c_stale;
        logic d_stale;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/core/tsp_queue.sv =====
// One stamp queue: shift-down register file with append and removal at any place.
`default_nettype none

module tsp_queue #(
    parameter int DEPTH = 16,
    parameter int TW    = 48
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [TW-1:0]              i_time,
    input  wire logic [tsp_pkg::IDX_W-1:0]  i_index,
    input  wire logic                       i_remove,
    input  wire logic [$clog2(DEPTH)-1:0]   i_rm_pos,
    input  wire logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic      [TW-1:0]              o_rd_time,
    output logic      [tsp_pkg::IDX_W-1:0]  o_rd_index,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [TW-1:0]             r_time  [DEPTH];
    logic [tsp_pkg::IDX_W-1:0] r_index [DEPTH];
    logic [CW-1:0]             r_count;

    // Entries: removal closes the gap, append writes behind the last entry.
    always_ff @(posedge i_clk) begin
        if (i_remove) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (AW'(i) >= i_rm_pos) begin
                    r_time[i]  <= r_time[i + 1];
                    r_index[i] <= r_index[i + 1];
                end
            end
        end else if (i_push) begin
            r_time[r_count[AW-1:0]]  <= i_time;
            r_index[r_count[AW-1:0]] <= i_index;
        end
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_remove) begin
            r_count <= r_count - 1'b1;
        end else if (i_push) begin
            r_count <= r_count + 1'b1;
        end
    end

    assign o_rd_time  = r_time[i_rd_addr];
    assign o_rd_index = r_index[i_rd_addr];
    assign o_count    = r_count;

endmodule

`default_nettype wire

// ===== rtl/core/tsp_datapath.sv =====
// Datapath: configuration, input capture, queues, gap search and result registers.
`default_nettype none

module tsp_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 48
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [tsp_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  wire logic [tsp_pkg::THR_W-1:0]    i_cfg_data,
    input  wire logic                         i_has_c,
    input  wire logic [tsp_pkg::IDX_W-1:0]    i_c_index,
    input  wire logic [TIME_BITS-1:0]         i_c_time,
    input  wire logic                         i_has_d,
    input  wire logic [tsp_pkg::IDX_W-1:0]    i_d_index,
    input  wire logic [TIME_BITS-1:0]         i_d_time,
    input  wire tsp_pkg::t_cmd                i_cmd,
    output tsp_pkg::t_stat                    o_stat,
    output logic                              o_match_valid,
    output logic [tsp_pkg::IDX_W-1:0]         o_pci,
    output logic [tsp_pkg::IDX_W-1:0]         o_pdi,
    output logic [TIME_BITS-1:0]              o_pct,
    output logic [TIME_BITS-1:0]              o_pdt,
    output logic [TIME_BITS:0]                o_gap,
    output logic [tsp_pkg::CNT32_W-1:0]       o_mt,
    output logic [tsp_pkg::CNT32_W-1:0]       o_cd,
    output logic [tsp_pkg::CNT32_W-1:0]       o_dd
);
    localparam int TW = TIME_BITS;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [tsp_pkg::THR_W-1:0]   r_thr;
    logic [tsp_pkg::MQ_W-1:0]    r_mq;
    logic                        r_has_c, r_has_d;
    logic [tsp_pkg::IDX_W-1:0]   r_c_index, r_d_index;
    logic [TW-1:0]               r_c_time, r_d_time;
    logic [AW-1:0]               r_ci, r_di, r_bc, r_bd;
    logic [TW-1:0]               r_best;
    logic                        r_best_vld;
    logic [tsp_pkg::CNT32_W-1:0] r_pairs, r_cdrop, r_ddrop;
    logic                        r_mv;
    logic [tsp_pkg::IDX_W-1:0]   r_pci, r_pdi;
    logic [TW-1:0]               r_pct, r_pdt;
    logic [TW:0]                 r_gap;
    logic [tsp_pkg::CNT32_W-1:0] r_mt, r_cd, r_dd;

    logic [7:0]                  mq8, lim8;
    logic [CW-1:0]               lim;
    logic [AW-1:0]               c_addr, d_addr, c_rm_pos, d_rm_pos;
    logic [TW-1:0]               c_rd_time, d_rd_time, gap;
    logic [tsp_pkg::IDX_W-1:0]   c_rd_index, d_rd_index;
    logic [CW-1:0]               c_count, d_count, c_last, d_last;
    logic [TW:0]                 stale_sum;
    logic                        c_rm, d_rm;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= tsp_pkg::THR_RESET;
            r_mq  <= tsp_pkg::MQ_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == tsp_pkg::REG_THRESHOLD) begin
                r_thr <= i_cfg_data;
            end else if (i_cfg_addr == tsp_pkg::REG_MAX_QUEUE) begin
                r_mq <= i_cfg_data[tsp_pkg::MQ_W-1:0];
            end
        end
    end

    // Queue limit, clamped to two and to the queue depth.
    always_comb begin
        mq8  = {3'b000, r_mq};
        lim8 = mq8;
        if (r_mq < tsp_pkg::MQ_MIN) begin
            lim8 = {3'b000, tsp_pkg::MQ_MIN};
        end else if (mq8 > 8'(QUEUE_DEPTH)) begin
            lim8 = 8'(QUEUE_DEPTH);
        end
        lim = CW'(lim8);
    end

    // Input item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_has_c   <= i_has_c;
            r_has_d   <= i_has_d;
            r_c_index <= i_c_index;
            r_d_index <= i_d_index;
            r_c_time  <= i_c_time;
            r_d_time  <= i_d_time;
        end
    end

    assign c_last = c_count - 1'b1;
    assign d_last = d_count - 1'b1;

    // Read address and removal position selection.
    always_comb begin
        c_addr = r_ci;
        d_addr = r_di;
        case (i_cmd.rsel)
            tsp_pkg::t_RS_SCAN: begin
                c_addr = r_ci;
                d_addr = r_di;
            end
            tsp_pkg::t_RS_BEST: begin
                c_addr = r_bc;
                d_addr = r_bd;
            end
            tsp_pkg::t_RS_STALE_C: begin
                c_addr = '0;
                d_addr = d_last[AW-1:0];
            end
            tsp_pkg::t_RS_STALE_D: begin
                c_addr = c_last[AW-1:0];
                d_addr = '0;
            end
            default: begin
                c_addr = r_ci;
                d_addr = r_di;
            end
        endcase
        c_rm     = i_cmd.c_drop | i_cmd.pair;
        d_rm     = i_cmd.d_drop | i_cmd.pair;
        c_rm_pos = i_cmd.pair ? r_bc : '0;
        d_rm_pos = i_cmd.pair ? r_bd : '0;
    end

    tsp_queue #(.DEPTH(QUEUE_DEPTH), .TW(TW)) u_cq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_cmd.c_push),
        .i_time     (r_c_time),
        .i_index    (r_c_index),
        .i_remove   (c_rm),
        .i_rm_pos   (c_rm_pos),
        .i_rd_addr  (c_addr),
        .o_rd_time  (c_rd_time),
        .o_rd_index (c_rd_index),
        .o_count    (c_count)
    );

    tsp_queue #(.DEPTH(QUEUE_DEPTH), .TW(TW)) u_dq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_cmd.d_push),
        .i_time     (r_d_time),
        .i_index    (r_d_index),
        .i_remove   (d_rm),
        .i_rm_pos   (d_rm_pos),
        .i_rd_addr  (d_addr),
        .o_rd_time  (d_rd_time),
        .o_rd_index (d_rd_index),
        .o_count    (d_count)
    );

    // Absolute gap of the pair under the read ports, and the staleness sum.
    assign gap       = (c_rd_time >= d_rd_time) ? (c_rd_time - d_rd_time)
                                                : (d_rd_time - c_rd_time);
    assign stale_sum = (i_cmd.rsel == tsp_pkg::t_RS_STALE_C)
                     ? ({1'b0, c_rd_time} + (TW + 1)'(r_thr))
                     : ({1'b0, d_rd_time} + (TW + 1)'(r_thr));

    // Pair scan: one color/depth pair per cycle, color-major, first minimum kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_vld <= 1'b0;
            r_ci       <= '0;
            r_di       <= '0;
        end else if (i_cmd.scan_clear) begin
            r_best_vld <= 1'b0;
            r_ci       <= '0;
            r_di       <= '0;
        end else if (i_cmd.scan_step) begin
            if (!r_best_vld || gap < r_best) begin
                r_best_vld <= 1'b1;
                r_best     <= gap;
                r_bc       <= r_ci;
                r_bd       <= r_di;
            end
            if (CW'(r_di) == d_last) begin
                r_di <= '0;
                r_ci <= r_ci + 1'b1;
            end else begin
                r_di <= r_di + 1'b1;
            end
        end
    end

    // Running counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs <= '0;
            r_cdrop <= '0;
            r_ddrop <= '0;
        end else begin
            if (i_cmd.pair) begin
                r_pairs <= r_pairs + 1'b1;
            end
            if (i_cmd.c_drop) begin
                r_cdrop <= r_cdrop + 1'b1;
            end
            if (i_cmd.d_drop) begin
                r_ddrop <= r_ddrop + 1'b1;
            end
        end
    end

    // Result register: a matched pair, or a status-only item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pair) begin
            r_mv  <= 1'b1;
            r_pci <= c_rd_index;
            r_pdi <= d_rd_index;
            r_pct <= c_rd_time;
            r_pdt <= d_rd_time;
            r_gap <= {1'b0, c_rd_time} - {1'b0, d_rd_time};
            r_mt  <= r_pairs + 1'b1;
            r_cd  <= r_cdrop;
            r_dd  <= r_ddrop;
        end else if (i_cmd.status_load) begin
            r_mv  <= 1'b0;
            r_pci <= '0;
            r_pdi <= '0;
            r_pct <= '0;
            r_pdt <= '0;
            r_gap <= '0;
            r_mt  <= r_pairs;
            r_cd  <= r_cdrop;
            r_dd  <= r_ddrop;
        end
    end

    assign o_match_valid = r_mv;
    assign o_pci         = r_pci;
    assign o_pdi         = r_pdi;
    assign o_pct         = r_pct;
    assign o_pdt         = r_pdt;
    assign o_gap         = r_gap;
    assign o_mt          = r_mt;
    assign o_cd          = r_cd;
    assign o_dd          = r_dd;

    // Status toward the controller.
    always_comb begin
        o_stat.c_trim    = (c_count > lim) || (r_has_c && (c_count >= lim));
        o_stat.d_trim    = (d_count > lim) || (r_has_d && (d_count >= lim));
        o_stat.has_c     = r_has_c;
        o_stat.has_d     = r_has_d;
        o_stat.c_empty   = (c_count == '0);
        o_stat.d_empty   = (d_count == '0);
        o_stat.scan_last = (CW'(r_ci) == c_last) && (CW'(r_di) == d_last);
        o_stat.best_ok   = (r_best <= TW'(r_thr));
        o_stat.c_stale   = stale_sum < {1'b0, d_rd_time};
        o_stat.d_stale   = stale_sum < {1'b0, c_rd_time};
    end

endmodule

`default_nettype wire

// ===== rtl/core/tsp_ctrl.sv =====
// Controller: sequences queue upkeep, pair search, drops and result hand-off.
`default_nettype none

module tsp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output logic                o_out_last,
    input  wire logic           i_out_ready,
    input  wire tsp_pkg::t_stat i_stat,
    output tsp_pkg::t_cmd       o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_C_FIX, S_D_FIX, S_CHECK, S_SCAN, S_DECIDE, S_PAIR,
        S_EMIT_MID, S_STALE_C, S_STALE_D, S_PREP, S_EMIT_LAST
    } t_state;

    t_state                            r_state;
    logic                              r_pend;
    logic [tsp_pkg::RES_CNT_W-1:0]     r_n;

    // State, pending-result flag and result count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_n     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_n     <= '0;
                        r_state <= S_C_FIX;
                    end
                end
                S_C_FIX: begin
                    if (!i_stat.c_trim) begin
                        r_state <= S_D_FIX;
                    end
                end
                S_D_FIX: begin
                    if (!i_stat.d_trim) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_n == tsp_pkg::RES_CNT_W'(tsp_pkg::MAX_RESULTS) ||
                        i_stat.c_empty || i_stat.d_empty) begin
                        r_state <= S_PREP;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_stat.scan_last) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (!i_stat.best_ok) begin
                        r_state <= S_STALE_C;
                    end else if (r_pend) begin
                        r_state <= S_EMIT_MID;
                    end else begin
                        r_state <= S_PAIR;
                    end
                end
                S_PAIR: begin
                    r_pend  <= 1'b1;
                    r_n     <= r_n + 1'b1;
                    r_state <= S_CHECK;
                end
                S_EMIT_MID: begin
                    if (i_out_ready) begin
                        r_pend  <= 1'b0;
                        r_state <= S_PAIR;
                    end
                end
                S_STALE_C: begin
                    r_state <= i_stat.c_stale ? S_CHECK : S_STALE_D;
                end
                S_STALE_D: begin
                    r_state <= i_stat.d_stale ? S_CHECK : S_PREP;
                end
                S_PREP: begin
                    r_state <= S_EMIT_LAST;
                end
                S_EMIT_LAST: begin
                    if (i_out_ready) begin
                        r_pend  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Commands decoded from the state and the datapath status.
    always_comb begin
        o_cmd             = '0;
        o_cmd.rsel        = tsp_pkg::t_RS_SCAN;
        o_cmd.load        = (r_state == S_IDLE) && i_in_valid;
        o_cmd.c_drop      = ((r_state == S_C_FIX) && i_stat.c_trim) ||
                            ((r_state == S_STALE_C) && i_stat.c_stale);
        o_cmd.c_push      = (r_state == S_C_FIX) && !i_stat.c_trim && i_stat.has_c;
        o_cmd.d_drop      = ((r_state == S_D_FIX) && i_stat.d_trim) ||
                            ((r_state == S_STALE_D) && i_stat.d_stale);
        o_cmd.d_push      = (r_state == S_D_FIX) && !i_stat.d_trim && i_stat.has_d;
        o_cmd.scan_clear  = (r_state == S_CHECK);
        o_cmd.scan_step   = (r_state == S_SCAN);
        o_cmd.pair        = (r_state == S_PAIR);
        o_cmd.status_load = (r_state == S_PREP) && !r_pend;
        case (r_state)
            S_PAIR:    o_cmd.rsel = tsp_pkg::t_RS_BEST;
            S_STALE_C: o_cmd.rsel = tsp_pkg::t_RS_STALE_C;
            S_STALE_D: o_cmd.rsel = tsp_pkg::t_RS_STALE_D;
            default:   o_cmd.rsel = tsp_pkg::t_RS_SCAN;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT_MID) || (r_state == S_EMIT_LAST);
    assign o_out_last  = (r_state == S_EMIT_LAST);

endmodule

`default_nettype wire

// ===== rtl/core/two_stream_timestamp_pairing.sv =====
// Top level of the two-stream timestamp pairing block.
//
//  Channel  | Direction | Contents
//  s_axis   | in        | tuser {has_depth, has_color}; tdata color/depth stamps
//  m_axis   | out       | tuser match_valid; tlast last_of_run; tdata pair and counters
//  cfg      | in        | write enable, register index, 24-bit data
//
// One item at a time. An item passes trimming, then search rounds; a round can reach
// the depth staleness test, and the search can end on an empty queue or the result
// limit. Each earlier pair result is offered before the next pair is taken.
// The pair scan reads one color/depth pair per cycle through one read port on each queue.
// Reset clears the fills, counters and configuration.
// A stalled result item holds the block; the next input item waits for it.
`default_nettype none

module two_stream_timestamp_pairing #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 48
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: color_frame_index, color_time_us, depth_frame_index, depth_time_us, zeros
    input  wire logic [((64 + 2*TIME_BITS + 7)/8)*8-1:0] s_axis_tdata,
    // tuser: has_color, has_depth
    input  wire logic [1:0]                          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata: paired_color_index, paired_depth_index, paired_color_time,
    // paired_depth_time, signed_gap_us, matched_total, color_drops, depth_drops, zeros
    output logic [((161 + 3*TIME_BITS + 7)/8)*8-1:0] m_axis_tdata,
    // tuser: match_valid
    output logic [0:0]                               m_axis_tuser,
    output logic                                     m_axis_tlast,
    input  wire logic                                i_cfg_we,
    input  wire logic [tsp_pkg::CFG_AW-1:0]          i_cfg_addr,
    input  wire logic [tsp_pkg::THR_W-1:0]           i_cfg_data
);
    localparam int TW    = TIME_BITS;
    localparam int OUT_W = ((161 + 3*TW + 7)/8)*8;

    tsp_pkg::t_cmd             cmd;
    tsp_pkg::t_stat            stat;
    logic                      mv;
    logic [tsp_pkg::IDX_W-1:0] pci, pdi;
    logic [TW-1:0]             pct, pdt;
    logic [TW:0]               gap;
    logic [31:0]               mt, cd, dd;

    tsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_last  (m_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tsp_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TW)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_has_c       (s_axis_tuser[0]),
        .i_c_index     (s_axis_tdata[31:0]),
        .i_c_time      (s_axis_tdata[32 +: TW]),
        .i_has_d       (s_axis_tuser[1]),
        .i_d_index     (s_axis_tdata[32 + TW +: 32]),
        .i_d_time      (s_axis_tdata[64 + TW +: TW]),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_match_valid (mv),
        .o_pci         (pci),
        .o_pdi         (pdi),
        .o_pct         (pct),
        .o_pdt         (pdt),
        .o_gap         (gap),
        .o_mt          (mt),
        .o_cd          (cd),
        .o_dd          (dd)
    );

    // Result packing: paired color index in the lowest bits, depth drops in the highest.
    assign m_axis_tdata = OUT_W'({dd, cd, mt, gap, pdt, pct, pdi, pci});
    assign m_axis_tuser = mv;

endmodule

`default_nettype wire

// ===== rtl/core/tsp_checker.sv =====
// Port-level checker for the two-stream timestamp pairing block, with its bind.
`default_nettype none

module tsp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic       m_axis_tlast,
    input wire logic [0:0] m_axis_tuser
);
    // The block never offers a result while it takes a new item.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is offered");

    // An accepted item makes the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready right after an accepted item");

    // A status-only result is always the last of its run.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("status result without last");

    // A stalled result stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

endmodule

bind two_stream_timestamp_pairing tsp_checker u_tsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
